### src/serial_idle_gap_frame_receiver_core_defines.svh
// Assertion macros shared by the idle-gap frame receiver RTL.
// Needs clk_i and rst_ni in the scope of every use.
`ifndef SERIAL_IDLE_GAP_FRAME_RECEIVER_CORE_DEFINES_SVH
`define SERIAL_IDLE_GAP_FRAME_RECEIVER_CORE_DEFINES_SVH

// same-cycle implication
`define SIGFR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sigfr assertion failed");

// next-cycle implication
`define SIGFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sigfr assertion failed");

`endif

### src/sigfr_pkg.sv
// Shared constants and types of the idle-gap frame receiver.
// No dependencies.
`default_nettype none
package sigfr_pkg;

  localparam int FRAME_DEPTH = 64;
  localparam int ADDR_W      = $clog2(FRAME_DEPTH);
  localparam int CNT_W       = $clog2(FRAME_DEPTH + 1);

  localparam int BYTE_W   = 8;
  localparam int IDLE_W   = 8;
  localparam int POS_W    = 6;
  localparam int LEN_W    = 7;
  localparam int OUT_W    = 24;

  localparam logic [IDLE_W-1:0] TIMEOUT_RESET = 8'd20;
  localparam logic [IDLE_W-1:0] IDLE_MAX      = 8'd255;

  // configuration register indexes (word address paddr[2])
  localparam logic REG_IDLE_TIMEOUT = 1'b0;

  typedef enum logic {
    MODE_BYTE = 1'b0,
    MODE_TICK = 1'b1
  } mode_e;

  // frame store write port
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
  } store_wr_t;

  // closed frame handed from front to back
  typedef struct packed {
    logic             push;
    logic [CNT_W-1:0] len;
  } frame_cmd_t;

endpackage
`default_nettype wire

### src/serial_idle_gap_frame_receiver_core.sv
// Top level of the idle-gap serial frame receiver: APB register, front, queue, back.
// Depends on sigfr_pkg, sigfr_front, sigfr_queue, sigfr_back.
//
// Input beats carry either a received byte (tuser = 0) or one tick of the
// millisecond time base (tuser = 1). Bytes are stored in a 64-entry frame
// store until it is full; each stored byte clears the idle counter and opens
// a frame. Ticks advance the saturating idle counter; when a frame is open and
// the count exceeds idle_timeout (APB register at byte address 0, reset 20),
// the frame closes and its bytes leave on the master stream in order, each
// with its position and the frame length, tlast on the final one. Tick beats
// are always accepted; byte beats are accepted only while no closed frame is
// queued or being read out. Each byte of a closed frame is read from the
// single-port-read store, then presented and held until downstream takes it;
// byte beats are held off while that readout runs, ticks are still accepted. The
// frame store needs no clearing after reset: only written entries are read.
`default_nettype none
module serial_idle_gap_frame_receiver_core import sigfr_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // APB configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // slave stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  wire logic        s_axis_tuser,   // [0] mode
  // master stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [7:0] frame_byte, [13:8] byte_position,
                                           // [20:14] frame_length, [23:21] zero
  output logic             m_axis_tlast    // last_byte
);

  logic [IDLE_W-1:0] timeout_q;
  logic              cfg_wr;

  store_wr_t         store_wr;
  frame_cmd_t        cmd;
  logic              q_valid, q_pop, busy;
  logic [CNT_W-1:0]  q_len;
  logic [BYTE_W-1:0] out_byte;
  logic [POS_W-1:0]  out_pos;
  logic [LEN_W-1:0]  out_len;

  // register file: one word, selected by paddr[2]; other word reads zero
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_IDLE_TIMEOUT);
  assign prdata = (paddr[2] == REG_IDLE_TIMEOUT) ? {24'd0, timeout_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_wr) begin
      timeout_q <= pwdata[IDLE_W-1:0];
    end
  end

  sigfr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_mode_i  (s_axis_tuser),
    .in_byte_i  (s_axis_tdata),
    .timeout_i  (timeout_q),
    .busy_i     (busy),
    .store_wr_o (store_wr),
    .cmd_o      (cmd)
  );

  // holds closed-frame lengths until the back end picks them up
  sigfr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .len_o   (q_len)
  );

  sigfr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .store_wr_i  (store_wr),
    .q_valid_i   (q_valid),
    .q_len_i     (q_len),
    .q_pop_o     (q_pop),
    .busy_o      (busy),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (out_byte),
    .out_pos_o   (out_pos),
    .out_len_o   (out_len),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, out_len, out_pos, out_byte};

endmodule
`default_nettype wire

### src/sigfr_front.sv
// Input side: classifies beats, fills the frame store, runs the idle timer.
// Depends on sigfr_pkg and the assertion macro header.
`default_nettype none
`include "serial_idle_gap_frame_receiver_core_defines.svh"
module sigfr_front import sigfr_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              in_mode_i,
  input  wire logic [BYTE_W-1:0] in_byte_i,
  input  wire logic [IDLE_W-1:0] timeout_i,
  input  wire logic              busy_i,
  output store_wr_t              store_wr_o,
  output frame_cmd_t             cmd_o
);

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [IDLE_W-1:0] idle_q, idle_d, idle_inc;
  logic              started_q, started_d;
  logic              accept;
  logic              room;

  // bytes wait while the back end still reads the store; ticks never wait
  assign in_ready_o = !((in_mode_i == MODE_BYTE) && busy_i);
  assign accept     = in_valid_i && in_ready_o;
  assign room       = cnt_q < CNT_W'(FRAME_DEPTH);
  assign idle_inc   = (idle_q == IDLE_MAX) ? idle_q : idle_q + 8'd1;

  always_comb begin
    cnt_d      = cnt_q;
    idle_d     = idle_q;
    started_d  = started_q;
    store_wr_o = '{en: 1'b0, addr: cnt_q[ADDR_W-1:0], data: in_byte_i};
    cmd_o      = '{push: 1'b0, len: cnt_q};
    if (accept) begin
      if (in_mode_i == MODE_BYTE) begin
        if (room) begin
          store_wr_o.en = 1'b1;
          cnt_d         = cnt_q + 1'b1;
          idle_d        = '0;
          started_d     = 1'b1;
        end
      end else begin
        idle_d = idle_inc;
        if (started_q && (idle_inc > timeout_i)) begin
          cmd_o.push = 1'b1;
          cnt_d      = '0;
          started_d  = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      idle_q    <= '0;
      started_q <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      idle_q    <= idle_d;
      started_q <= started_d;
    end
  end

  `SIGFR_ASSERT_IMPL(a_started_has_bytes, started_q, cnt_q != '0)
  `SIGFR_ASSERT_IMPL(a_no_write_while_busy, store_wr_o.en, !busy_i)
  `SIGFR_ASSERT_NEXT(a_close_clears, cmd_o.push, (cnt_q == '0) && !started_q)

endmodule
`default_nettype wire

### src/sigfr_queue.sv
// Two-entry queue of closed-frame lengths between front and back.
// Depends on sigfr_pkg.
`default_nettype none
module sigfr_queue import sigfr_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire frame_cmd_t       cmd_i,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output logic [CNT_W-1:0]      len_o
);

  logic [CNT_W-1:0] slot_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       fill_q;

  assign valid_o = fill_q != 2'd0;
  assign len_o   = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      slot_q[wr_ptr_q] <= cmd_i.len;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (cmd_i.push) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)      rd_ptr_q <= !rd_ptr_q;
      fill_q <= fill_q + {1'b0, cmd_i.push} - {1'b0, pop_i};
    end
  end

endmodule
`default_nettype wire

### src/sigfr_back.sv
// Output side: frame store memory and the sequencer that reads a closed frame out.
// Depends on sigfr_pkg and the assertion macro header.
`default_nettype none
`include "serial_idle_gap_frame_receiver_core_defines.svh"
module sigfr_back import sigfr_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire store_wr_t         store_wr_i,
  input  wire logic              q_valid_i,
  input  wire logic [CNT_W-1:0]  q_len_i,
  output logic                   q_pop_o,
  output logic                   busy_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [BYTE_W-1:0]      out_byte_o,
  output logic [POS_W-1:0]       out_pos_o,
  output logic [LEN_W-1:0]       out_len_o,
  output logic                   out_last_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SHOW
  } state_e;

  logic [BYTE_W-1:0] mem [FRAME_DEPTH];
  logic [BYTE_W-1:0] rd_data_q;
  logic              rd_en;

  state_e            state_q;
  logic [ADDR_W-1:0] idx_q;
  logic [CNT_W-1:0]  len_q;
  logic              valid_q;
  logic              last;

  assign q_pop_o = (state_q == S_IDLE) && q_valid_i;
  assign busy_o  = (state_q != S_IDLE) || q_valid_i;
  assign rd_en   = state_q == S_READ;
  assign last    = (CNT_W'(idx_q) + 1'b1) == len_q;

  always_ff @(posedge clk_i) begin
    if (store_wr_i.en) begin
      mem[store_wr_i.addr] <= store_wr_i.data;
    end
    if (rd_en) begin
      rd_data_q <= mem[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      len_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            len_q   <= q_len_i;
            idx_q   <= '0;
            state_q <= S_READ;
          end
        end
        S_READ: begin
          valid_q <= 1'b1;
          state_q <= S_SHOW;
        end
        S_SHOW: begin
          if (out_ready_i) begin
            valid_q <= 1'b0;
            if (last) begin
              state_q <= S_IDLE;
            end else begin
              idx_q   <= idx_q + 1'b1;
              state_q <= S_READ;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = rd_data_q;
  assign out_pos_o   = POS_W'(idx_q);
  assign out_len_o   = LEN_W'(len_q);
  assign out_last_o  = last;

  `SIGFR_ASSERT_IMPL(a_valid_in_range, valid_q, (len_q != '0) && (CNT_W'(idx_q) < len_q))
  `SIGFR_ASSERT_IMPL(a_valid_only_show, valid_q, state_q == S_SHOW)
  `SIGFR_ASSERT_NEXT(a_pop_starts, q_pop_o, (state_q == S_READ) && (idx_q == '0))

endmodule
`default_nettype wire

### tb/testbench.sv
// Self-checking testbench of serial_idle_gap_frame_receiver_core: stream beats in,
// frame bytes out, checked against a cycle-free model of the idle-gap framing.
// Depends on sigfr_pkg and the receiver RTL.
`timescale 1ns / 1ps
module testbench import sigfr_pkg::*;;

  localparam int          LIMIT_CYCLES   = 200_000;
  localparam int          HOLDOFF_CYCLES = 600;
  localparam logic [2:0]  TIMEOUT_ADDR   = {REG_IDLE_TIMEOUT, 2'b00};

  // one beat of a closed frame, as the master stream should carry it
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [POS_W-1:0]  pos;
    logic [LEN_W-1:0]  len;
    logic              last;
  } frame_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] rx_byte
  logic        s_axis_tuser = 1'b0; // [0] mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // [7:0] byte, [13:8] position, [20:14] length
  logic        m_axis_tlast;

  serial_idle_gap_frame_receiver_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  // framing model state
  logic [BYTE_W-1:0] frame_copy [FRAME_DEPTH];
  int                stored_count = 0;
  logic [IDLE_W-1:0] idle_count = '0;
  bit                frame_open = 1'b0;
  logic [IDLE_W-1:0] timeout_reg = TIMEOUT_RESET;
  frame_beat_t       pending_beats [$];

  int mismatches = 0;
  int cycle_count = 0;
  int beats_sent = 0;

  // sender burst shaping
  int gap_max = 0;
  int burst_max = 1;
  int burst_left = 1;
  bit valid_held = 1'b0;

  // receiver stall shaping; a hold-off is asked for by bumping holdoff_asked
  int stall_pct = 0;
  int holdoff_asked = 0;
  int holdoff_served = 0;
  int holdoff_left = 0;

  initial forever #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycle_count,
               pending_beats.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // Advance the framing model by one accepted input beat and queue any
  // frame bytes it releases.
  function automatic void predict_beat(mode_e mode, logic [BYTE_W-1:0] rx);
    frame_beat_t b;
    if (mode == MODE_BYTE) begin
      // full store: byte dropped, idle counter untouched
      if (stored_count < FRAME_DEPTH) begin
        frame_copy[stored_count] = rx;
        stored_count++;
        idle_count = '0;
        frame_open = 1'b1;
      end
    end else begin
      if (idle_count < IDLE_MAX) idle_count++;
      if (frame_open && idle_count > timeout_reg) begin
        for (int k = 0; k < stored_count; k++) begin
          b.data = frame_copy[k];
          b.pos  = POS_W'(k);
          b.len  = LEN_W'(stored_count);
          b.last = (k == stored_count - 1);
          pending_beats.push_back(b);
        end
        frame_open = 1'b0;
        stored_count = 0;
      end
    end
  endfunction

  // Offer one beat, wait for the handshake, then maybe end the burst.
  // tvalid is left high between beats of a burst.
  task automatic send_beat(mode_e mode, logic [BYTE_W-1:0] rx);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= rx;
    valid_held = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_beat(mode, rx);
    beats_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, burst_max);
      if (gap_max > 0) begin
        s_axis_tvalid <= 1'b0;
        valid_held = 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk_i);
      end
    end
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_beat(MODE_TICK, 8'($urandom));
  endtask

  task automatic send_bytes(int n);
    repeat (n) send_beat(MODE_BYTE, 8'($urandom));
  endtask

  // Sender goes quiet until every queued frame byte has come out.
  task automatic wait_results_drained;
    if (valid_held) begin
      s_axis_tvalid <= 1'b0;
      valid_held = 1'b0;
    end
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Optional APB write of idle_timeout, always followed by a read-back.
  // psel stays high from the write access into the read setup.
  task automatic access_timeout(bit do_write, logic [IDLE_W-1:0] value);
    if (do_write) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= TIMEOUT_ADDR;
      pwdata  <= 32'(value);
      @(posedge clk_i);
      penable <= 1'b1;
      @(posedge clk_i);
      timeout_reg = value;
      penable <= 1'b0;
      pwrite  <= 1'b0;
    end else begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= TIMEOUT_ADDR;
    end
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== 32'(timeout_reg)) report_mismatch("idle_timeout readback", prdata,
                                                     32'(timeout_reg));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_timeout(logic [IDLE_W-1:0] value);
    wait_results_drained();
    access_timeout(1'b1, value);
  endtask

  // receiver: random stalls, or a long hold-off when one is asked for
  always @(posedge clk_i) begin
    if (holdoff_asked != holdoff_served) begin
      holdoff_left = HOLDOFF_CYCLES;
      holdoff_served++;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // frame byte checker
  always @(posedge clk_i) begin
    frame_beat_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_beats.size() == 0) begin
        report_mismatch("unexpected frame beat", 32'(m_axis_tdata), 32'hffff_ffff);
      end else begin
        want = pending_beats.pop_front();
        if (m_axis_tdata[7:0] !== want.data)
          report_mismatch("frame_byte", 32'(m_axis_tdata[7:0]), 32'(want.data));
        if (m_axis_tdata[13:8] !== want.pos)
          report_mismatch("byte_position", 32'(m_axis_tdata[13:8]), 32'(want.pos));
        if (m_axis_tdata[20:14] !== want.len)
          report_mismatch("frame_length", 32'(m_axis_tdata[20:14]), 32'(want.len));
        if (m_axis_tdata[23:21] !== 3'b000)
          report_mismatch("tdata pad", 32'(m_axis_tdata[23:21]), 32'd0);
        if (m_axis_tlast !== want.last)
          report_mismatch("last_byte", 32'(m_axis_tlast), 32'(want.last));
      end
    end
  end

  // Reset value of the timeout: 20 ticks keep the frame open, the 21st closes it.
  task automatic test_reset_timeout;
    access_timeout(1'b0, '0);
    send_beat(MODE_BYTE, 8'h3c);
    send_ticks(TIMEOUT_RESET + 1);
  endtask

  task automatic test_directed_cases;
    set_timeout(8'd1);
    send_beat(MODE_TICK, 8'h00);   // tick with no frame open
    send_beat(MODE_BYTE, 8'h00);
    send_beat(MODE_BYTE, 8'hff);
    send_beat(MODE_BYTE, 8'h55);
    send_beat(MODE_BYTE, 8'haa);
    send_ticks(2);                 // second tick closes
    send_ticks(1);                 // idle keeps counting after close
    send_beat(MODE_BYTE, 8'h80);
    send_ticks(2);                 // single-byte frame
    set_timeout(8'd0);
    send_beat(MODE_BYTE, 8'h01);
    send_beat(MODE_BYTE, 8'h7e);
    send_ticks(1);                 // timeout 0: first tick closes
  endtask

  // Store fills at FRAME_DEPTH under timeout 255; the extra bytes are dropped.
  task automatic test_full_store;
    set_timeout(8'd255);
    gap_max   = 3;
    burst_max = 10;
    stall_pct = 20;
    send_bytes(FRAME_DEPTH + 2);
  endtask

  // Timeout 255 never closes; the idle counter pins at 255, and a dropped
  // byte must not restart it.
  task automatic test_idle_saturation;
    send_ticks(256);
    send_beat(MODE_BYTE, 8'($urandom));
  endtask

  // Timeout 254 lets the pinned counter close the full frame on one tick.
  // A long receiver hold-off then backs the following byte beats up.
  task automatic test_output_backpressure;
    set_timeout(8'd254);
    gap_max   = 0;
    stall_pct = 0;
    holdoff_asked++;
    send_ticks(1);
    send_bytes(6);
    set_timeout(8'd0);
    send_ticks(1);
    wait_results_drained();
  endtask

  // Mostly well-formed frames with random content, some noise beats.
  task automatic random_phase(int n_items, int gmax, int bmax, int stall,
                              logic [IDLE_W-1:0] timeout);
    int start;
    int n;
    int ticks;
    set_timeout(timeout);
    gap_max   = gmax;
    burst_max = bmax;
    stall_pct = stall;
    start = beats_sent;
    while (beats_sent - start < n_items) begin
      if ($urandom_range(0, 9) < 8) begin
        n = ($urandom_range(0, 11) == 0) ? $urandom_range(8, 16)
                                         : $urandom_range(1, 6);
        send_bytes(n);
        // sometimes one tick short, so the next bytes extend the frame
        ticks = int'(timeout) + (($urandom_range(0, 5) == 0) ? 0 : 1);
        send_ticks(ticks + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0));
      end else begin
        send_beat(mode_e'($urandom_range(0, 1)), 8'($urandom));
      end
    end
  endtask

  task automatic test_random_traffic;
    random_phase(16, 0, 1, 0, 8'd0);                 // no idling on either side
    random_phase(16, 4, 8, 30, 8'($urandom_range(1, 2)));
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_timeout();
    test_directed_cases();
    test_full_store();
    test_idle_saturation();
    test_output_backpressure();
    test_random_traffic();
    wait_results_drained();
    repeat (16) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
